// ===== hdl/kct_pkg.sv =====
// Shared constants, codes and structs of the key count table.
package kct_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	localparam count_t COUNT_TOP = '1;
	localparam idx_t   IDX_LAST  = IDX_BITS'(ENTRIES - 1);

	// Item kinds; the unused code behaves as a query.
	typedef enum logic [1:0] {
		KIND_INC   = 2'd0,
		KIND_DEC   = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	// Operating mode of the shared compare unit.
	typedef enum logic {
		MODE_MATCH = 1'b0,
		MODE_RANK  = 1'b1
	} mode_t;

	// Control from the sequencer to the compare unit.
	typedef struct packed {
		logic  step;
		mode_t mode;
		logic  first;
	} unit_ctl_t;

	// Accumulated results of the compare unit.
	typedef struct packed {
		logic   found;
		idx_t   found_idx;
		logic   free;
		idx_t   free_idx;
		logic   any;
		key_t   hi_key;
		count_t hi_cnt;
		key_t   lo_key;
		count_t lo_cnt;
	} unit_acc_t;

	// Write request into the slot table.
	typedef struct packed {
		logic   en;
		idx_t   idx;
		logic   key_en;
		key_t   key;
		count_t cnt;
	} tbl_wr_t;

endpackage

// ===== hdl/kct_table.sv =====
// Slot table: per-slot key and count registers with one read and one write port.
module kct_table (
	input  logic             clk,
	input  logic             arst_n,
	input  kct_pkg::tbl_wr_t wr,
	input  kct_pkg::idx_t    rd_idx,
	output kct_pkg::key_t    rd_key,
	output kct_pkg::count_t  rd_cnt
);

	kct_pkg::key_t   keys_q   [kct_pkg::ENTRIES];
	kct_pkg::count_t counts_q [kct_pkg::ENTRIES];

	// Counts reset to zero, which marks every slot free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kct_pkg::ENTRIES; i++) begin
				counts_q[i] <= '0;
			end
		end else if (wr.en) begin
			counts_q[wr.idx] <= wr.cnt;
		end
	end

	// Keys are only read from occupied slots, so they need no reset.
	always_ff @(posedge clk) begin
		if (wr.en && wr.key_en) begin
			keys_q[wr.idx] <= wr.key;
		end
	end

	assign rd_key = keys_q[rd_idx];
	assign rd_cnt = counts_q[rd_idx];

endmodule

// ===== hdl/kct_unit.sv =====
// Shared compare unit: key match and free-slot search, then min/max ranking.
module kct_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  kct_pkg::unit_ctl_t  ctl,
	input  kct_pkg::idx_t       idx,
	input  kct_pkg::key_t       entry_key,
	input  kct_pkg::count_t     entry_cnt,
	input  kct_pkg::key_t       match_key,
	output kct_pkg::unit_acc_t  acc
);

	kct_pkg::unit_acc_t acc_q;
	kct_pkg::unit_acc_t prev;
	kct_pkg::unit_acc_t acc_d;
	logic               occupied;
	logic               hit;
	logic               hi_wins;
	logic               lo_wins;

	// The first entry of a pass starts from an empty accumulator.
	always_comb begin
		prev = acc_q;
		if (ctl.first) begin
			prev.found = 1'b0;
			prev.free  = 1'b0;
			prev.any   = 1'b0;
		end
	end

	assign occupied = (entry_cnt != '0);
	assign hit      = occupied && (entry_key == match_key);
	assign hi_wins  = (entry_cnt > prev.hi_cnt) ||
		((entry_cnt == prev.hi_cnt) && (entry_key > prev.hi_key));
	assign lo_wins  = (entry_cnt < prev.lo_cnt) ||
		((entry_cnt == prev.lo_cnt) && (entry_key < prev.lo_key));

	// One entry per step: the lowest matching and lowest free slot, or the ranking.
	always_comb begin
		acc_d = prev;
		if (ctl.mode == kct_pkg::MODE_MATCH) begin
			if (hit && !prev.found) begin
				acc_d.found     = 1'b1;
				acc_d.found_idx = idx;
			end
			if (!occupied && !prev.free) begin
				acc_d.free     = 1'b1;
				acc_d.free_idx = idx;
			end
		end else if (occupied) begin
			if (!prev.any) begin
				acc_d.any    = 1'b1;
				acc_d.hi_key = entry_key;
				acc_d.hi_cnt = entry_cnt;
				acc_d.lo_key = entry_key;
				acc_d.lo_cnt = entry_cnt;
			end else begin
				if (hi_wins) begin
					acc_d.hi_key = entry_key;
					acc_d.hi_cnt = entry_cnt;
				end
				if (lo_wins) begin
					acc_d.lo_key = entry_key;
					acc_d.lo_cnt = entry_cnt;
				end
			end
		end
	end

	// Accumulator register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= acc_d;
		end
	end

	assign acc = acc_q;

endmodule

// ===== hdl/key_count_table_min_max.sv =====
// Key count table: sequencer around the slot table and the shared compare unit.
// A new item is not accepted while the block is busy.
// Start is taken again in the done cycle.
// Each item takes two passes of the single compare unit, one slot per cycle each.
// Reset (arst_n low) frees every slot and returns the sequencer to idle at once.
// The done strobe lasts one cycle and the receiver cannot stall it.
module key_count_table_min_max (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] key,
	output logic        done,
	output logic [1:0]  status,
	output logic        nonempty,
	output logic [31:0] max_key,
	output logic [31:0] min_key,
	output logic [15:0] max_count,
	output logic [15:0] min_count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_UPDATE,
		S_RANK,
		S_DONE
	} state_t;

	state_t              state_q;
	kct_pkg::idx_t       idx_q;
	logic [1:0]          kind_q;
	kct_pkg::key_t       key_q;
	kct_pkg::status_t    status_q;
	kct_pkg::status_t    status_d;
	kct_pkg::unit_ctl_t  ctl;
	kct_pkg::unit_acc_t  acc;
	kct_pkg::tbl_wr_t    wr;
	kct_pkg::idx_t       rd_idx;
	kct_pkg::key_t       rd_key;
	kct_pkg::count_t     rd_cnt;
	logic                accept;

	assign busy   = (state_q != S_IDLE) && (state_q != S_DONE);
	assign accept = start && !busy;

	kct_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd_key (rd_key),
		.rd_cnt (rd_cnt)
	);

	kct_unit u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.idx       (idx_q),
		.entry_key (rd_key),
		.entry_cnt (rd_cnt),
		.match_key (key_q),
		.acc       (acc)
	);

	// Step the compare unit over one slot per cycle in both passes.
	always_comb begin
		ctl.step  = (state_q == S_MATCH) || (state_q == S_RANK);
		ctl.mode  = (state_q == S_RANK) ? kct_pkg::MODE_RANK : kct_pkg::MODE_MATCH;
		ctl.first = (idx_q == '0);
		rd_idx    = (state_q == S_UPDATE) ? acc.found_idx : idx_q;
	end

	// Table update and status, decided once the match pass is over.
	always_comb begin
		wr.en     = 1'b0;
		wr.idx    = acc.found_idx;
		wr.key_en = 1'b0;
		wr.key    = key_q;
		wr.cnt    = rd_cnt;
		status_d  = kct_pkg::ST_OK;
		case (kind_q)
			kct_pkg::KIND_INC: begin
				if (acc.found) begin
					wr.en  = (rd_cnt != kct_pkg::COUNT_TOP);
					wr.cnt = rd_cnt + kct_pkg::count_t'(1);
				end else if (acc.free) begin
					wr.en     = 1'b1;
					wr.idx    = acc.free_idx;
					wr.key_en = 1'b1;
					wr.cnt    = kct_pkg::count_t'(1);
				end else begin
					status_d = kct_pkg::ST_FULL;
				end
			end
			kct_pkg::KIND_DEC: begin
				if (acc.found) begin
					wr.en  = 1'b1;
					wr.cnt = rd_cnt - kct_pkg::count_t'(1);
				end else begin
					status_d = kct_pkg::ST_ABSENT;
				end
			end
			default: begin
			end
		endcase
		if (state_q != S_UPDATE) begin
			wr.en = 1'b0;
		end
	end

	// Sequencer: state, slot index, captured item and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			kind_q   <= kct_pkg::KIND_QUERY;
			key_q    <= '0;
			status_q <= kct_pkg::ST_OK;
		end else begin
			unique case (state_q) inside
				S_IDLE, S_DONE: begin
					if (accept) begin
						state_q <= S_MATCH;
						idx_q   <= '0;
						kind_q  <= kind;
						key_q   <= kct_pkg::key_t'(key);
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MATCH: begin
					if (idx_q == kct_pkg::IDX_LAST) begin
						state_q <= S_UPDATE;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + kct_pkg::idx_t'(1);
					end
				end
				S_UPDATE: begin
					state_q  <= S_RANK;
					status_q <= status_d;
				end
				S_RANK: begin
					if (idx_q == kct_pkg::IDX_LAST) begin
						state_q <= S_DONE;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + kct_pkg::idx_t'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result ports; an empty table reports zeros.
	assign done      = (state_q == S_DONE);
	assign status    = status_q;
	assign nonempty  = acc.any;
	assign max_key   = acc.any ? 32'(acc.hi_key) : '0;
	assign min_key   = acc.any ? 32'(acc.lo_key) : '0;
	assign max_count = acc.any ? 16'(acc.hi_cnt) : '0;
	assign min_count = acc.any ? 16'(acc.lo_cnt) : '0;

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe lasted more than one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !nonempty) |-> (max_count == '0 && min_count == '0 && max_key == '0))
		else $error("empty table reported nonzero results");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && nonempty) |-> (min_count <= max_count && min_count != '0))
		else $error("minimum count above maximum or zero");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == kct_pkg::ST_FULL) |-> nonempty)
		else $error("full status reported with an empty table");
`endif

endmodule
